// ----- hw/rtl/rivc_pkg.sv -----
// Shared types and codes for the run interval set coalescer.
package rivc_pkg;

    // Widths of the fixed stream fields.
    localparam int RUN_W    = 32;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    // Stream packing widths, padded to whole bytes.
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 72;

    // Operation carried in s_tuser.
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_STORED    = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_FULL      = 3'd2,
        ST_READ_OK   = 3'd3,
        ST_BAD_INDEX = 3'd4
    } status_t;

    // Control sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RDWAIT,
        S_SRCH,
        S_SCMP,
        S_NB_LO,
        S_NB_HI,
        S_DECIDE,
        S_SHIFT,
        S_PUT,
        S_OUT
    } state_t;

endpackage

// ----- hw/rtl/run_interval_set_coalescer.sv -----
// Top level of the run interval set coalescer: a sorted range table in one memory.
//
//  Channel   Direction  Handshake          Payload
//  s_*       in         s_tvalid/s_tready  s_tuser: opcode; s_tdata: run_number, read_index
//  m_*       out        m_tvalid/m_tready  m_tuser: status; m_tdata: first, last, count
//
// A read fetches the entry, captures it in S_RDWAIT and goes to the hand-off; a read whose
// index lies beyond the count goes straight to the hand-off. An add runs a binary search
// over the n held ranges (ceil(log2(n+1)) steps, each a read in S_SRCH and a compare in S_SCMP),
// fetches the neighbors and decides, then moves one entry per cycle when a range is inserted
// or two ranges are joined, and drains the copy pipeline before the hand-off.
// The pace is set by the single table memory, which reads one entry and writes one a cycle.
// Reset clears the state, range count, pending flag and output valid only; table entries above
// the count are never read, so no clearing pass runs. A new item is taken while a result waits
// in the output register; the sequencer holds its finished result until that register is free.
module run_interval_set_coalescer #(
    parameter int NUM_RANGES = 64,
    parameter int RUN_BITS   = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: [31:0] run_number, [37:32] read_index, [39:38] zero
    input  logic [rivc_pkg::S_DATA_W-1:0]  s_tdata,
    // s_tuser: [0] opcode
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: [31:0] range_first, [63:32] range_last, [70:64] range_count, [71] zero
    output logic [rivc_pkg::M_DATA_W-1:0]  m_tdata,
    // m_tuser: [2:0] status
    output logic [rivc_pkg::STATUS_W-1:0]  m_tuser
);

    localparam int IDX_W = $clog2(NUM_RANGES);
    localparam int CNT_W = $clog2(NUM_RANGES + 1);
    localparam int ENT_W = 2 * RUN_BITS;
    localparam int XW    = (CNT_W > rivc_pkg::INDEX_W) ? CNT_W : rivc_pkg::INDEX_W;

    // Range table: each entry holds {first, last}.
    logic [ENT_W-1:0] mem [NUM_RANGES];
    logic [ENT_W-1:0] rd_data_reg;
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    logic [ENT_W-1:0] mem_wdata;

    // Control registers.
    rivc_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic             pend_reg, pend_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // Working registers.
    logic [RUN_BITS-1:0]   run_reg, run_next;
    logic [CNT_W-1:0]      lo_reg, lo_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [IDX_W-1:0]      mid_reg, mid_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic [ENT_W-1:0]      below_reg, below_next;
    logic [IDX_W-1:0]      src_reg, src_next;
    logic [IDX_W-1:0]      dst_reg, dst_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic                  up_reg, up_next;
    rivc_pkg::status_t     res_status_reg, res_status_next;
    logic [rivc_pkg::RUN_W-1:0] res_first_reg, res_first_next;
    logic [rivc_pkg::RUN_W-1:0] res_last_reg, res_last_next;
    logic [rivc_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [rivc_pkg::STATUS_W-1:0] m_tuser_reg, m_tuser_next;

    // Decode of the input transfer.
    logic [RUN_BITS-1:0]         in_run;
    logic [rivc_pkg::INDEX_W-1:0] in_index;
    logic [XW-1:0]               index_x;
    logic [XW-1:0]               total_x;
    logic                        accept;

    // Decision terms.
    logic [CNT_W:0]        mid_sum;
    logic [RUN_BITS-1:0]   b_first, b_last, a_first, a_last, rd_first;
    logic                  has_below, has_above;
    logic                  present, touch_b, touch_a;

    assign in_run   = RUN_BITS'({32'd0, s_tdata[rivc_pkg::RUN_W-1:0]});
    assign in_index = s_tdata[rivc_pkg::RUN_W +: rivc_pkg::INDEX_W];
    assign index_x  = XW'(in_index);
    assign total_x  = XW'(total_reg);

    assign s_tready = (state_reg == rivc_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign rd_first  = rd_data_reg[ENT_W-1:RUN_BITS];
    assign b_first   = below_reg[ENT_W-1:RUN_BITS];
    assign b_last    = below_reg[RUN_BITS-1:0];
    assign a_first   = rd_data_reg[ENT_W-1:RUN_BITS];
    assign a_last    = rd_data_reg[RUN_BITS-1:0];
    assign has_below = (pos_reg != '0);
    assign has_above = (pos_reg < total_reg);
    // The range below ends before the run unless the run is present, so no wrap arises.
    assign present   = has_below && (b_last >= run_reg);
    assign touch_b   = has_below && (RUN_BITS'(b_last + 1'b1) == run_reg);
    assign touch_a   = has_above && (RUN_BITS'(run_reg + 1'b1) == a_first);

    // Table memory: one write and one registered read a cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rivc_pkg::S_IDLE;
            total_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        run_reg        <= run_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        pos_reg        <= pos_next;
        below_reg      <= below_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        rem_reg        <= rem_next;
        up_reg         <= up_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        res_last_reg   <= res_last_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    // Sequencer: search, neighbor fetch, decision, entry moves and result hand-off.
    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        pend_next       = pend_reg;
        m_tvalid_next   = m_tvalid_reg;
        run_next        = run_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        pos_next        = pos_reg;
        below_next      = below_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        rem_next        = rem_reg;
        up_next         = up_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        res_last_next   = res_last_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = '0;
        mem_raddr       = '0;
        mem_wdata       = '0;

        // The output register empties on its own transfer.
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            rivc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    run_next       = in_run;
                    res_first_next = '0;
                    res_last_next  = '0;
                    if (s_tuser == rivc_pkg::OP_READ)
                    begin
                        if (index_x < total_x)
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = IDX_W'(in_index);
                            state_next = rivc_pkg::S_RDWAIT;
                        end
                        else
                        begin
                            res_status_next = rivc_pkg::ST_BAD_INDEX;
                            state_next      = rivc_pkg::S_OUT;
                        end
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = total_reg;
                        state_next = rivc_pkg::S_SRCH;
                    end
                end
            end

            rivc_pkg::S_RDWAIT:
            begin
                res_status_next = rivc_pkg::ST_READ_OK;
                res_first_next  = rivc_pkg::RUN_W'(rd_data_reg[ENT_W-1:RUN_BITS]);
                res_last_next   = rivc_pkg::RUN_W'(rd_data_reg[RUN_BITS-1:0]);
                state_next      = rivc_pkg::S_OUT;
            end

            // Binary search for the first entry whose first run lies above the run.
            rivc_pkg::S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = IDX_W'(mid_sum[CNT_W:1]);
                    mid_next   = IDX_W'(mid_sum[CNT_W:1]);
                    state_next = rivc_pkg::S_SCMP;
                end
                else
                begin
                    pos_next   = lo_reg;
                    state_next = rivc_pkg::S_NB_LO;
                end
            end

            rivc_pkg::S_SCMP:
            begin
                if (rd_first <= run_reg)
                begin
                    lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                end
                else
                begin
                    hi_next = CNT_W'(mid_reg);
                end
                state_next = rivc_pkg::S_SRCH;
            end

            // Fetch the range below the insertion point, then the one at it.
            rivc_pkg::S_NB_LO:
            begin
                mem_re     = has_below;
                mem_raddr  = IDX_W'(pos_reg - CNT_W'(1));
                state_next = rivc_pkg::S_NB_HI;
            end

            rivc_pkg::S_NB_HI:
            begin
                below_next = rd_data_reg;
                mem_re     = has_above;
                mem_raddr  = IDX_W'(pos_reg);
                state_next = rivc_pkg::S_DECIDE;
            end

            rivc_pkg::S_DECIDE:
            begin
                pend_next       = 1'b0;
                res_status_next = rivc_pkg::ST_STORED;
                state_next      = rivc_pkg::S_OUT;
                priority if (present)
                begin
                    res_status_next = rivc_pkg::ST_PRESENT;
                end
                else if (touch_b && touch_a)
                begin
                    // Join: the lower entry takes the upper end, the rest moves down.
                    mem_we     = 1'b1;
                    mem_waddr  = IDX_W'(pos_reg - CNT_W'(1));
                    mem_wdata  = {b_first, a_last};
                    total_next = total_reg - CNT_W'(1);
                    rem_next   = total_reg - pos_reg - CNT_W'(1);
                    src_next   = IDX_W'(pos_reg + CNT_W'(1));
                    up_next    = 1'b0;
                    if (total_reg - pos_reg != CNT_W'(1))
                    begin
                        state_next = rivc_pkg::S_SHIFT;
                    end
                end
                else if (touch_b)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = IDX_W'(pos_reg - CNT_W'(1));
                    mem_wdata = {b_first, run_reg};
                end
                else if (touch_a)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = IDX_W'(pos_reg);
                    mem_wdata = {run_reg, a_last};
                end
                else if (total_reg == CNT_W'(NUM_RANGES))
                begin
                    res_status_next = rivc_pkg::ST_FULL;
                end
                else
                begin
                    // New range: move the upper entries up by one, from the top.
                    total_next = total_reg + CNT_W'(1);
                    rem_next   = total_reg - pos_reg;
                    src_next   = IDX_W'(total_reg - CNT_W'(1));
                    up_next    = 1'b1;
                    state_next = has_above ? rivc_pkg::S_SHIFT : rivc_pkg::S_PUT;
                end
            end

            // Copy pipeline: read one entry, write it to its neighbor in the next cycle.
            rivc_pkg::S_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg;
                    mem_wdata = rd_data_reg;
                end
                if (rem_reg != '0)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = src_reg;
                    pend_next = 1'b1;
                    dst_next  = up_reg ? IDX_W'(src_reg + 1'b1) : IDX_W'(src_reg - 1'b1);
                    src_next  = up_reg ? IDX_W'(src_reg - 1'b1) : IDX_W'(src_reg + 1'b1);
                    rem_next  = rem_reg - CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = up_reg ? rivc_pkg::S_PUT : rivc_pkg::S_OUT;
                    end
                end
            end

            rivc_pkg::S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = IDX_W'(pos_reg);
                mem_wdata  = {run_reg, run_reg};
                state_next = rivc_pkg::S_OUT;
            end

            // Hand the result to the output register once it is free.
            rivc_pkg::S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {1'b0, rivc_pkg::COUNT_W'(total_reg),
                                     res_last_reg, res_first_reg};
                    state_next    = rivc_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = rivc_pkg::S_IDLE;
            end
        endcase
    end

    // The count never passes the table depth.
    assert property (@(posedge clk) disable iff (!rst_n) total_reg <= CNT_W'(NUM_RANGES))
        else $error("range count beyond table depth");

    // The count changes only on the decision cycle of an add.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != rivc_pkg::S_DECIDE) |=> $stable(total_reg))
        else $error("range count changed outside decision");

    // Entry moves never read the entry written in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_raddr != mem_waddr))
        else $error("table read and write collide");

    // No table write while idle or waiting to hand off a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rivc_pkg::S_IDLE || state_reg == rivc_pkg::S_OUT) |-> !mem_we)
        else $error("table written outside an add");

    // A result waiting in the output register is not overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |=> $stable(m_tdata_reg))
        else $error("stalled result overwritten");

endmodule

// ----- verif/testbench.sv -----
// Self-checking stream testbench for the run interval set coalescer.
`timescale 1ns / 100ps

module testbench;
    import rivc_pkg::*;

    localparam int NUM_RANGES   = 64;
    localparam int RUN_BITS     = 32;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int WINDOW_SPAN  = 160;

    // One input item and one result item, as the predictor sees them.
    typedef struct packed {
        logic               opcode;
        logic [RUN_W-1:0]   run;
        logic [INDEX_W-1:0] index;
    } run_item_t;

    typedef struct packed {
        status_t            status;
        logic [RUN_W-1:0]   first;
        logic [RUN_W-1:0]   last;
        logic [COUNT_W-1:0] count;
    } range_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = OP_ADD;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    // Predictor state: the sorted range table and the number of ranges held.
    logic [RUN_W-1:0] table_first [NUM_RANGES];
    logic [RUN_W-1:0] table_last  [NUM_RANGES];
    int unsigned      ranges_held = 0;

    run_item_t     pending_items [$];
    range_result_t predicted_results [$];
    int            accepted_count = 0;
    int            driver_seen = 0;
    int            cycle_count = 0;
    int            error_count = 0;
    int            results_checked = 0;
    int            status_seen [5] = '{0, 0, 0, 0, 0};

    run_interval_set_coalescer #(
        .NUM_RANGES(NUM_RANGES),
        .RUN_BITS  (RUN_BITS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // Free-running clock.
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Insert one run into the predicted table and return the add result.
    function automatic status_t insert_run(logic [RUN_W-1:0] run);
        int  pos;
        int  n;
        bit  touch_below;
        bit  touch_above;
        n = ranges_held;
        pos = 0;
        while (pos < n && table_first[pos] <= run)
            pos++;
        if (pos > 0 && table_last[pos-1] >= run)
            return ST_PRESENT;
        // Both differences are positive here, so no wrap can fake adjacency.
        touch_below = (pos > 0) && ((run - table_last[pos-1]) == 32'd1);
        touch_above = (pos < n) && ((table_first[pos] - run) == 32'd1);
        if (touch_below && touch_above)
        begin
            table_last[pos-1] = table_last[pos];
            for (int i = pos; i + 1 < n; i++)
            begin
                table_first[i] = table_first[i+1];
                table_last[i]  = table_last[i+1];
            end
            ranges_held = n - 1;
            return ST_STORED;
        end
        if (touch_below)
        begin
            table_last[pos-1] = run;
            return ST_STORED;
        end
        if (touch_above)
        begin
            table_first[pos] = run;
            return ST_STORED;
        end
        if (n >= NUM_RANGES)
            return ST_FULL;
        for (int i = n; i > pos; i--)
        begin
            table_first[i] = table_first[i-1];
            table_last[i]  = table_last[i-1];
        end
        table_first[pos] = run;
        table_last[pos]  = run;
        ranges_held = n + 1;
        return ST_STORED;
    endfunction

    // Work out the result that one accepted item causes.
    function automatic range_result_t coalesce_step(run_item_t item);
        range_result_t res;
        res = '0;
        if (item.opcode == OP_ADD)
            res.status = insert_run(item.run);
        else if (item.index < ranges_held)
        begin
            res.status = ST_READ_OK;
            res.first  = table_first[item.index];
            res.last   = table_last[item.index];
        end
        else
            res.status = ST_BAD_INDEX;
        res.count = ranges_held[COUNT_W-1:0];
        return res;
    endfunction

    // Unused fields carry random content so that the block must ignore them.
    function automatic void push_add(logic [RUN_W-1:0] run);
        run_item_t item;
        item.opcode = OP_ADD;
        item.run    = run;
        item.index  = INDEX_W'($urandom_range(0, 63));
        pending_items = {pending_items, item};
    endfunction

    function automatic void push_read(int idx);
        run_item_t item;
        item.opcode = OP_READ;
        item.run    = $urandom;
        item.index  = INDEX_W'(idx);
        pending_items = {pending_items, item};
    endfunction

    // Both sides idle about 9 times in 100, except in one quiet stretch.
    function automatic bit idle_now();
        if (cycle_count >= 30000 && cycle_count < 60000)
            return 1'b0;
        return $urandom_range(0, 99) < 9;
    endfunction

    // Cycle counter and run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Predict the result of every input transfer in acceptance order.
    always @(posedge clk)
    begin
        run_item_t seen_item;
        if (rst_n && s_tvalid && s_tready)
        begin
            seen_item = run_item_t'({s_tuser, s_tdata[31:0], s_tdata[37:32]});
            predicted_results = {predicted_results, coalesce_step(seen_item)};
            accepted_count++;
        end
    end

    // Input driver: hold the item until it transfers, then offer the next one.
    always @(negedge clk)
    begin
        run_item_t item;
        if (rst_n && (!s_tvalid || accepted_count != driver_seen))
        begin
            if (pending_items.size() != 0 && !idle_now())
            begin
                item = pending_items.pop_front();
                s_tuser  <= item.opcode;
                s_tdata  <= {2'b00, item.index, item.run};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
        driver_seen = accepted_count;
    end

    // Output stall pattern.
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= !idle_now();
    end

    // Compare each output transfer with the oldest prediction.
    always @(posedge clk)
    begin
        range_result_t want;
        range_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = status_t'(m_tuser);
            got.first  = m_tdata[31:0];
            got.last   = m_tdata[63:32];
            got.count  = m_tdata[70:64];
            if (predicted_results.size() == 0)
            begin
                $error("unexpected result: status %0d, no prediction waiting", m_tuser);
                error_count++;
            end
            else
            begin
                want = predicted_results.pop_front();
                results_checked++;
                if (want.status <= ST_BAD_INDEX)
                    status_seen[want.status]++;
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    error_count++;
                end
                if (got.first !== want.first)
                begin
                    $error("range_first: expected %0h, actual %0h", want.first, got.first);
                    error_count++;
                end
                if (got.last !== want.last)
                begin
                    $error("range_last: expected %0h, actual %0h", want.last, got.last);
                    error_count++;
                end
                if (got.count !== want.count)
                begin
                    $error("range_count: expected %0d, actual %0d", want.count, got.count);
                    error_count++;
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        logic [RUN_W-1:0] base;
        int               pick;

        // Directed part: empty table, joins at both ends of the run space.
        push_read(0);
        push_add(32'd0);
        push_add(32'd0);
        push_add(32'd2);
        push_add(32'd1);
        push_read(0);
        push_add(32'd4);
        push_add(32'd5);
        push_add(32'd3);
        push_read(0);
        push_add(32'hFFFF_FFFF);
        push_add(32'hFFFF_FFFD);
        push_add(32'hFFFF_FFFE);
        push_read(1);
        push_add(32'h8000_0000);
        push_add(32'h7FFF_FFFE);
        push_add(32'h7FFF_FFFF);
        push_add(32'h5555_5555);
        push_add(32'hAAAA_AAAA);
        push_read(2);
        push_read(3);
        push_read(4);
        push_read(63);

        // Random part in three windows: one anywhere, one at zero, one at the top.
        for (int round = 0; round < 3; round++)
        begin
            case (round)
                0:       base = $urandom_range(32'd0, 32'hFFFF_FF00);
                1:       base = 32'd0;
                default: base = 32'hFFFF_FFFF - (WINDOW_SPAN - 1);
            endcase
            // Spaced runs build many single-run ranges and fill the table.
            for (int k = 0; k < 120; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    push_read($urandom_range(0, 63));
                else if (pick < 20)
                    push_add($urandom);
                else
                    push_add(base + 2 * $urandom_range(0, WINDOW_SPAN / 2 - 1));
            end
            // Any run in the window: extensions, joins and a full table.
            for (int k = 0; k < 120; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    push_read($urandom_range(0, 63));
                else if (pick < 20)
                    push_add($urandom);
                else
                    push_add(base + $urandom_range(0, WINDOW_SPAN - 1));
            end
            // An ascending sweep collapses the window into few ranges.
            for (int k = 0; k < WINDOW_SPAN; k++)
                push_add(base + k);
            for (int k = 0; k < 64; k++)
                push_read(k);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_items.size() == 0);
        @(posedge clk);
        while (s_tvalid || predicted_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results: %0d stored, %0d present, %0d full,",
                 results_checked, status_seen[ST_STORED], status_seen[ST_PRESENT],
                 status_seen[ST_FULL]);
        $display("%0d reads in range, %0d reads beyond count, %0d ranges held at the end.",
                 status_seen[ST_READ_OK], status_seen[ST_BAD_INDEX], ranges_held);
        if (error_count == 0 && predicted_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/rivc_pkg.sv
hw/rtl/run_interval_set_coalescer.sv
verif/testbench.sv
